FILE: sv/gtsc_pkg.sv
// Package for the pad conditioner: payload types, constants and the darkness table.
package gtsc_pkg;

  localparam int NUM_PORTS = 4;
  localparam int NUM_TURBO = 2;
  localparam int PORT_W    = 2;
  localparam int KEY_W     = 10;
  localparam int CNT_W     = 8;
  localparam int ROW_W     = NUM_TURBO * CNT_W;
  localparam int ROW_AW    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 8;
  localparam int DARK_W    = 4;

  localparam int KEY_RIGHT = 4;
  localparam int KEY_LEFT  = 5;
  localparam int KEY_UP    = 6;
  localparam int KEY_DOWN  = 7;

  localparam logic [DARK_W-1:0] DARK_MAX   = 4'd10;
  localparam logic [7:0]        SOLAR_BASE = 8'hE8;

  typedef enum logic [CFG_AW-1:0] {
    CFG_TURBO_ENABLE = 2'd0,
    CFG_TURBO_DELAY  = 2'd1,
    CFG_SOLAR_ENABLE = 2'd2,
    CFG_JOYPAD_MASK  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [KEY_W-1:0]  buttons;
    logic              turbo_a_down;
    logic              turbo_b_down;
    logic              solar_down_button;
    logic              solar_up_button;
  } pad_in_t;

  typedef struct packed {
    logic [PORT_W-1:0] port_out;
    logic [KEY_W-1:0]  keys;
    logic [7:0]        solar_reading;
  } pad_out_t;

  // Amount subtracted from the base reading at each darkness step.
  function automatic logic [7:0] dark_level(input logic [DARK_W-1:0] idx);
    logic [7:0] lvl;
    case (idx)
      4'd0:    lvl = 8'h00;
      4'd1:    lvl = 8'h06;
      4'd2:    lvl = 8'h0E;
      4'd3:    lvl = 8'h18;
      4'd4:    lvl = 8'h20;
      4'd5:    lvl = 8'h28;
      4'd6:    lvl = 8'h38;
      4'd7:    lvl = 8'h48;
      4'd8:    lvl = 8'h60;
      4'd9:    lvl = 8'h78;
      default: lvl = 8'h98;
    endcase
    return lvl;
  endfunction

endpackage

FILE: sv/gtsc_ram.sv
// Generic single-write, single-read RAM with a registered, read-first output.
module gtsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gamepad_turbo_and_solar_conditioner_top.sv
// Pad conditioner top level: turbo counters in RAM, key cleanup and the solar stepper.
// An accepted item is registered into stage s1, where it meets the RAM read data, and
// its result is registered into out_data, where it is held while out_ready is low.
// Throughput: one item per cycle unless the output stalls. Turbo counters are read as an
// item enters s1 and written back as it leaves, the last write forwarded to its successor.
// Reset (rst, synchronous, active high) empties the pipeline, restores the configuration
// reset values, clears the solar state and the per-port valid bits, so every turbo counter
// reads as zero.
module gamepad_turbo_and_solar_conditioner_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gtsc_pkg::pad_in_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output gtsc_pkg::pad_out_t        out_data,
  input  logic                      cfg_we,
  input  logic [gtsc_pkg::CFG_AW-1:0] cfg_index,
  input  logic [gtsc_pkg::CFG_DW-1:0] cfg_data
);

  // Configuration registers.
  logic                           turbo_enable;
  logic [gtsc_pkg::CNT_W-1:0]     turbo_delay;
  logic                           solar_enable;
  logic [gtsc_pkg::NUM_PORTS-1:0] joypad_port_mask;

  // Solar state.
  logic [gtsc_pkg::DARK_W-1:0] darkness_index, darkness_index_next;
  logic                        solar_press_latch, solar_press_latch_next;
  logic [7:0]                  solar_value, solar_value_next;

  // Pipeline stage that meets the RAM read data.
  logic              s1_valid;
  gtsc_pkg::pad_in_t s1_item;
  logic              s1_adv;

  // Per-row valid bits and forwarding of the previous write.
  logic [gtsc_pkg::NUM_PORTS-1:0] row_valid;
  logic                           fwd_valid;
  logic [gtsc_pkg::ROW_AW-1:0]    fwd_row;
  logic [gtsc_pkg::ROW_W-1:0]     fwd_data;

  logic [gtsc_pkg::ROW_AW-1:0] rd_addr;
  logic [gtsc_pkg::ROW_AW-1:0] s1_addr;
  logic [gtsc_pkg::ROW_W-1:0]  ram_rdata;
  logic [gtsc_pkg::ROW_W-1:0]  cur_row;
  logic [gtsc_pkg::ROW_W-1:0]  new_row;
  logic                        wr_en;
  logic                        is_pad;
  logic [gtsc_pkg::KEY_W-1:0]  keys;
  logic                        sol_up;
  logic                        sol_dn;
  logic                        solar_step;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign s1_addr  = s1_item.port[gtsc_pkg::ROW_AW-1:0];
  // A stalled item keeps re-reading its own row so that the data stays current.
  assign rd_addr  = (s1_valid && !s1_adv) ? s1_addr : in_data.port[gtsc_pkg::ROW_AW-1:0];

  gtsc_ram #(
    .WIDTH(gtsc_pkg::ROW_W),
    .DEPTH(gtsc_pkg::NUM_PORTS)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_addr),
    .wdata(new_row),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    logic [gtsc_pkg::CNT_W-1:0] cnt;
    logic [gtsc_pkg::CNT_W:0]   inc;
    logic                       held;
    cnt  = '0;
    inc  = '0;
    held = 1'b0;

    is_pad = (int'(s1_item.port) < gtsc_pkg::NUM_PORTS) && joypad_port_mask[s1_addr];

    if (!row_valid[s1_addr]) begin
      cur_row = '0;
    end else if (fwd_valid && (fwd_row == s1_addr)) begin
      cur_row = fwd_data;
    end else begin
      cur_row = ram_rdata;
    end

    new_row = cur_row;
    keys    = is_pad ? s1_item.buttons : '0;

    if (is_pad && turbo_enable) begin
      for (int j = 0; j < gtsc_pkg::NUM_TURBO; j++) begin
        held = (j == 0) ? s1_item.turbo_a_down : s1_item.turbo_b_down;
        cnt  = cur_row[j*gtsc_pkg::CNT_W +: gtsc_pkg::CNT_W];
        if (held) begin
          keys[j] = (cnt == '0);
          inc     = {1'b0, cnt} + 1'b1;
          new_row[j*gtsc_pkg::CNT_W +: gtsc_pkg::CNT_W] =
            (inc > {1'b0, turbo_delay}) ? '0 : inc[gtsc_pkg::CNT_W-1:0];
        end else begin
          new_row[j*gtsc_pkg::CNT_W +: gtsc_pkg::CNT_W] = '0;
        end
      end
    end

    // Up with down cancels first; only otherwise does left with right cancel.
    if (keys[gtsc_pkg::KEY_UP] && keys[gtsc_pkg::KEY_DOWN]) begin
      keys[gtsc_pkg::KEY_UP]   = 1'b0;
      keys[gtsc_pkg::KEY_DOWN] = 1'b0;
    end else if (keys[gtsc_pkg::KEY_LEFT] && keys[gtsc_pkg::KEY_RIGHT]) begin
      keys[gtsc_pkg::KEY_LEFT]  = 1'b0;
      keys[gtsc_pkg::KEY_RIGHT] = 1'b0;
    end
  end

  assign wr_en = s1_adv && is_pad && turbo_enable;

  assign solar_step = (s1_item.port == '0) && solar_enable;
  assign sol_up     = solar_step && is_pad && s1_item.solar_up_button;
  assign sol_dn     = solar_step && is_pad && s1_item.solar_down_button;

  always_comb begin
    darkness_index_next    = darkness_index;
    solar_press_latch_next = solar_press_latch;
    solar_value_next       = solar_value;
    if (solar_step) begin
      if (sol_up || sol_dn) begin
        if (!solar_press_latch) begin
          solar_press_latch_next = 1'b1;
          if (sol_up) begin
            darkness_index_next = (darkness_index < gtsc_pkg::DARK_MAX) ?
                                  darkness_index + 1'b1 : gtsc_pkg::DARK_MAX;
          end else if (darkness_index != '0) begin
            darkness_index_next = darkness_index - 1'b1;
          end
          solar_value_next = gtsc_pkg::SOLAR_BASE - gtsc_pkg::dark_level(darkness_index_next);
        end
      end else begin
        solar_press_latch_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turbo_enable      <= 1'b0;
      turbo_delay       <= '0;
      solar_enable      <= 1'b0;
      joypad_port_mask  <= '1;
      darkness_index    <= '0;
      solar_press_latch <= 1'b0;
      solar_value       <= '0;
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
      row_valid         <= '0;
      fwd_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gtsc_pkg::CFG_TURBO_ENABLE: turbo_enable     <= cfg_data[0];
          gtsc_pkg::CFG_TURBO_DELAY:  turbo_delay      <= cfg_data[gtsc_pkg::CNT_W-1:0];
          gtsc_pkg::CFG_SOLAR_ENABLE: solar_enable     <= cfg_data[0];
          gtsc_pkg::CFG_JOYPAD_MASK:  joypad_port_mask <= cfg_data[gtsc_pkg::NUM_PORTS-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid         <= 1'b1;
        darkness_index    <= darkness_index_next;
        solar_press_latch <= solar_press_latch_next;
        solar_value       <= solar_value_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        row_valid[s1_addr] <= 1'b1;
      end
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
    if (s1_adv) begin
      out_data.port_out      <= s1_item.port;
      out_data.keys          <= keys;
      out_data.solar_reading <= solar_value_next;
    end
    if (wr_en) begin
      fwd_row  <= s1_addr;
      fwd_data <= new_row;
    end
  end

endmodule

FILE: sv/gtsc_checker.sv
// Port-level checker for the pad conditioner, bound to the top level.
module gtsc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input gtsc_pkg::pad_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  a_no_up_down: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.keys[gtsc_pkg::KEY_UP] && out_data.keys[gtsc_pkg::KEY_DOWN]))
    else $error("up and down both set in key word");

  a_left_right: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.keys[gtsc_pkg::KEY_LEFT] && out_data.keys[gtsc_pkg::KEY_RIGHT]
    |-> !out_data.keys[gtsc_pkg::KEY_UP] && !out_data.keys[gtsc_pkg::KEY_DOWN])
    else $error("left and right both set although up and down were not cancelled");

  a_solar_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.solar_reading <= gtsc_pkg::SOLAR_BASE)
    else $error("solar reading above base value");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind gamepad_turbo_and_solar_conditioner_top gtsc_checker u_gtsc_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

FILE: tb/sv/tb_gamepad_turbo_and_solar_conditioner_top.sv
// Self-checking testbench for the pad conditioner: directed and random pad samples.
`timescale 1ns / 1ps

module tb_gamepad_turbo_and_solar_conditioner_top;
  import gtsc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 80;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 150;

  // Predicts the conditioned key word of every accepted sample and checks results in order.
  class conditioned_key_checker;
    bit         turbo_on    = 1'b0;
    bit [7:0]   turbo_limit = 8'd0;
    bit         solar_on    = 1'b0;
    bit [3:0]   pad_mask    = 4'hF;
    bit [7:0]   turbo_cnt [NUM_PORTS][NUM_TURBO];
    bit [3:0]   dark_idx    = 4'd0;
    bit         press_held  = 1'b0;
    bit [7:0]   shown_reading = 8'd0;
    bit [7:0]   shade_step [11] = '{8'h00, 8'h06, 8'h0E, 8'h18, 8'h20, 8'h28,
                                    8'h38, 8'h48, 8'h60, 8'h78, 8'h98};
    pad_out_t   expected_keys [$];
    int         mismatches = 0;

    function void set_register(input cfg_index_t idx, input logic [7:0] val);
      case (idx)
        CFG_TURBO_ENABLE: turbo_on    = val[0];
        CFG_TURBO_DELAY:  turbo_limit = val;
        CFG_SOLAR_ENABLE: solar_on    = val[0];
        CFG_JOYPAD_MASK:  pad_mask    = val[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_keys.size();
    endfunction

    function void note_sample(input pad_in_t s);
      pad_out_t    e;
      logic [9:0]  k;
      logic [1:0]  held;
      bit          dn;
      bit          up;
      int          nxt;
      k  = '0;
      dn = 1'b0;
      up = 1'b0;
      if (pad_mask[s.port]) begin
        k = s.buttons;
        if (turbo_on) begin
          held = {s.turbo_b_down, s.turbo_a_down};
          for (int j = 0; j < NUM_TURBO; j++) begin
            if (held[j]) begin
              k[j] = (turbo_cnt[s.port][j] == 8'd0);
              nxt = turbo_cnt[s.port][j] + 1;
              if (nxt > turbo_limit) nxt = 0;
              turbo_cnt[s.port][j] = nxt[7:0];
            end else begin
              turbo_cnt[s.port][j] = 8'd0;
            end
          end
        end
        if (s.port == 2'd0 && solar_on) begin
          dn = s.solar_down_button;
          up = s.solar_up_button;
        end
      end
      // Up with down takes priority over left with right.
      if (k[KEY_UP] && k[KEY_DOWN]) begin
        k[KEY_UP]   = 1'b0;
        k[KEY_DOWN] = 1'b0;
      end else if (k[KEY_LEFT] && k[KEY_RIGHT]) begin
        k[KEY_LEFT]  = 1'b0;
        k[KEY_RIGHT] = 1'b0;
      end
      if (s.port == 2'd0 && solar_on) begin
        if (up || dn) begin
          if (!press_held) begin
            press_held = 1'b1;
            if (up) begin
              if (dark_idx < 4'd10) dark_idx++;
            end else if (dark_idx > 4'd0) begin
              dark_idx--;
            end
            shown_reading = 8'hE8 - shade_step[dark_idx];
          end
        end else begin
          press_held = 1'b0;
        end
      end
      e.port_out      = s.port;
      e.keys          = k;
      e.solar_reading = shown_reading;
      expected_keys.push_back(e);
    endfunction

    task report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_key_word(input pad_out_t got);
      pad_out_t e;
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      e = expected_keys.pop_front();
      if (got.port_out != e.port_out)
        report_mismatch($sformatf("port_out %0d, expected %0d", got.port_out, e.port_out));
      if (got.keys != e.keys)
        report_mismatch($sformatf("keys %h, expected %h (port %0d)",
                                  got.keys, e.keys, e.port_out));
      if (got.solar_reading != e.solar_reading)
        report_mismatch($sformatf("solar_reading %h, expected %h",
                                  got.solar_reading, e.solar_reading));
    endtask
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  pad_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  pad_out_t   out_data;
  logic       cfg_we    = 1'b0;
  cfg_index_t cfg_index = CFG_TURBO_ENABLE;
  logic [7:0] cfg_data  = 8'd0;

  conditioned_key_checker sb = new;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  gamepad_turbo_and_solar_conditioner_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_sample(in_data);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_key_word(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // All driving tasks start and end on a falling edge.
  task automatic send_sample(input pad_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(input bit te, input logic [7:0] td,
                                input bit se, input logic [3:0] pm);
    cfg_index_t idx;
    logic [7:0] val;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_index_t'(i);
      case (idx)
        CFG_TURBO_ENABLE: val = {7'd0, te};
        CFG_TURBO_DELAY:  val = td;
        CFG_SOLAR_ENABLE: val = {7'd0, se};
        default:          val = {4'd0, pm};
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      sb.set_register(idx, val);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly held turbo buttons on one port and press/release patterns on the
  // solar buttons, with a share of fully random samples as noise.
  function automatic pad_in_t random_sample(input logic [1:0] focus);
    pad_in_t s;
    int      r;
    s.port         = ($urandom_range(99) < 75) ? focus : 2'($urandom_range(3));
    s.buttons      = 10'($urandom_range(1023));
    s.turbo_a_down = ($urandom_range(99) < 80);
    s.turbo_b_down = ($urandom_range(99) < 65);
    r = $urandom_range(99);
    s.solar_down_button = (r >= 75);
    s.solar_up_button   = (r >= 45 && r < 75) || (r >= 92);
    if ($urandom_range(99) < 10) s = pad_in_t'(16'($urandom()));
    return s;
  endfunction

  initial begin
    logic [1:0] focus;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    apply_settings(1'b1, 8'd2, 1'b1, 4'hF);
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0000}));
    send_sample(pad_in_t'({2'd0, 10'h3FF, 4'b0000}));
    send_sample(pad_in_t'({2'd1, 10'h030, 4'b0000}));
    send_sample(pad_in_t'({2'd2, 10'h0F0, 4'b0000}));
    send_sample(pad_in_t'({2'd3, 10'h0C3, 4'b0000}));
    // Turbo A held on port 1 through one full wrap of the counter.
    repeat (4) send_sample(pad_in_t'({2'd1, 10'h000, 4'b1000}));
    send_sample(pad_in_t'({2'd1, 10'h001, 4'b0100}));
    send_sample(pad_in_t'({2'd1, 10'h003, 4'b0100}));
    // Solar steps: press, hold, release, step down to the floor, both buttons.
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0001}));
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0001}));
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0000}));
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0010}));
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0000}));
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0010}));
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0000}));
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0011}));
    send_sample(pad_in_t'({2'd1, 10'h000, 4'b0001}));
    wait_drained();

    // Ports 0 and 2 are not pads, and turbo is switched off.
    apply_settings(1'b0, 8'd2, 1'b1, 4'b1010);
    send_sample(pad_in_t'({2'd0, 10'h3FF, 4'b1111}));
    send_sample(pad_in_t'({2'd0, 10'h000, 4'b0001}));
    send_sample(pad_in_t'({2'd1, 10'h0F3, 4'b1100}));
    send_sample(pad_in_t'({2'd2, 10'h3FF, 4'b1100}));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(1'b1, 8'd0, 1'b1, 4'hF);
        1: apply_settings(1'b1, 8'd255, 1'b1, 4'hF);
        2: apply_settings(1'b0, 8'd3, 1'b0, 4'h0);
        3: apply_settings(1'b1, 8'd1, 1'b1, 4'b1110);
        default: apply_settings(1'($urandom_range(1)),
                                8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                             : $urandom_range(6)),
                                1'($urandom_range(1)), 4'($urandom_range(15)));
      endcase
      send_idle_pct = (p < 3) ? 16 : (p < 6) ? 68 : 0;
      recv_idle_pct = (p < 3) ? 68 : (p < 6) ? 16 : 0;
      focus = 2'(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 6 && n == 50) hold_requests++;
        if (p == 4 && n == 100) wait_drained();
        send_sample(random_sample(focus));
      end
      wait_drained();
    end

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
